// File: hw/rtl/mst_pkg.sv
// shared constants for the masked subnet table: field widths, request kinds,
// result status codes and the default table depth
// no dependencies
`timescale 1ns / 1ps

package mst_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned ENTRIES_DEF = 16;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

// File: hw/rtl/mst_req_if.sv
// request channel of the masked subnet table: valid/ready plus request payload
// depends on mst_pkg
`timescale 1ns / 1ps

interface mst_req_if;
    import mst_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   prefix_mask;

    modport source (output valid, output kind, output address, output prefix_mask,
                    input ready);
    modport sink   (input valid, input kind, input address, input prefix_mask,
                    output ready);
endinterface

// File: hw/rtl/mst_rsp_if.sv
// result channel of the masked subnet table: valid/ready plus hit and status
// depends on mst_pkg
`timescale 1ns / 1ps

interface mst_rsp_if;
    import mst_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output hit, output status, input ready);
    modport sink   (input valid, input hit, input status, output ready);
endinterface

// File: hw/rtl/mst_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mst_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/masked_subnet_table_top.sv
// masked subnet table top level: sequencer, fill count, shared entry comparator
// depends on mst_pkg, mst_req_if, mst_rsp_if and mst_ram
`timescale 1ns / 1ps

// masked subnet table. holds up to ENTRIES (address, mask) pairs in a single
// ram, filled from slot 0 upward; the fill count alone says which slots are
// live, so stored words need no reset and there is no clearing pass. every
// request gives exactly one result. insert scans the live entries for the same
// pair: found gives hit 1 / status duplicate, a full table gives status full,
// otherwise the pair is appended. clear drops the fill count to zero. match
// scans for any entry with ((address ^ entry_addr) & entry_mask) == 0. unused
// kind codes answer hit 0, status done. timing: one request at a time; insert
// and match scan the live entries before their result loads, clear and no-op
// go straight to the result, and the next request is taken in the cycle after
// the result loads. the scan reads one entry per cycle through the ram's
// single read port and checks it in one shared comparator. a result sits in
// an output register, so the next request is taken while the previous result
// still waits.

module masked_subnet_table_top #(
    parameter int unsigned ENTRIES = mst_pkg::ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mst_req_if.sink    req,
    mst_rsp_if.source  rsp
);
    import mst_pkg::*;

    localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
    localparam int unsigned ENTRY_W = 2 * ADDR_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t              state_reg,      state_next;
    logic [CNT_W-1:0]    fill_reg,       fill_next;
    logic [CNT_W-1:0]    rd_idx_reg,     rd_idx_next;
    logic                cmp_valid_reg,  cmp_valid_next;
    logic                found_reg,      found_next;
    logic [KIND_W-1:0]   kind_reg,       kind_next;
    logic [ADDR_W-1:0]   addr_reg,       addr_next;
    logic [ADDR_W-1:0]   mask_reg,       mask_next;
    logic                res_hit_reg,    res_hit_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg,  out_valid_next;
    logic                out_hit_reg,    out_hit_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                req_take;
    logic                issue;
    logic                scan_done;
    logic                wr_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic [ADDR_W-1:0]   e_addr;
    logic [ADDR_W-1:0]   e_mask;
    logic [ADDR_W-1:0]   sel_mask;
    logic [ADDR_W-1:0]   extra;
    logic                entry_hit;
    logic                is_insert;
    logic                load_out;

    // entry storage: address in the upper half, mask in the lower half
    mst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data ({addr_reg, mask_reg}),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign e_addr = rd_data[ENTRY_W-1:ADDR_W];
    assign e_mask = rd_data[ADDR_W-1:0];

    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign is_insert = (kind_reg == KIND_INSERT);

    // scan: read one live slot per cycle, compare it in the next cycle
    assign issue     = (state_reg == ST_SCAN) && (rd_idx_reg < fill_reg);
    assign scan_done = (state_reg == ST_SCAN) && !issue && !cmp_valid_reg;

    // shared comparator: insert wants an exact pair, match wants masked equality
    assign sel_mask  = is_insert ? {ADDR_W{1'b1}} : e_mask;
    assign extra     = is_insert ? (mask_reg ^ e_mask) : {ADDR_W{1'b0}};
    assign entry_hit = (((addr_reg ^ e_addr) & sel_mask) | extra) == {ADDR_W{1'b0}};

    // append only when the pair is new and there is room
    assign wr_en = scan_done && is_insert && !found_reg && (fill_reg != FULL_CNT);

    assign load_out = (state_reg == ST_RESULT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = issue;
        found_next      = found_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        res_hit_next    = res_hit_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    kind_next       = req.kind;
                    addr_next       = req.address;
                    mask_next       = req.prefix_mask;
                    rd_idx_next     = '0;
                    found_next      = 1'b0;
                    res_hit_next    = 1'b0;
                    res_status_next = STATUS_DONE;
                    if (req.kind == KIND_INSERT || req.kind == KIND_MATCH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        if (req.kind == KIND_CLEAR)
                        begin
                            fill_next = '0;
                        end
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (cmp_valid_reg && entry_hit)
                begin
                    found_next = 1'b1;
                end
                if (scan_done)
                begin
                    state_next = ST_RESULT;
                    if (is_insert)
                    begin
                        if (found_reg)
                        begin
                            res_hit_next    = 1'b1;
                            res_status_next = STATUS_DUP;
                        end
                        else if (fill_reg == FULL_CNT)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_hit_next = found_reg;
                    end
                end
            end
            ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register parts the result side from the sequencer
    always_comb
    begin
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_hit_next    = res_hit_reg;
            out_status_next = res_status_reg;
        end
        else if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            kind_reg      <= KIND_INSERT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        mask_reg       <= mask_next;
        res_hit_reg    <= res_hit_next;
        res_status_reg <= res_status_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.hit    = out_hit_reg;
    assign rsp.status = out_status_reg;

endmodule

// File: hw/rtl/mst_checker.sv
// port-level checker for the masked subnet table, bound to the top level
// depends on mst_pkg and masked_subnet_table_top
`timescale 1ns / 1ps

module mst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_hit,
    input logic [mst_pkg::STATUS_W-1:0]  rsp_status
);
    import mst_pkg::*;

    // one request at a time: the block is busy right after taking one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_status))
        else $error("result changed while stalled");

    // duplicate always reports hit, full never does
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STATUS_DONE |-> rsp_hit == (rsp_status == STATUS_DUP))
        else $error("hit disagrees with status");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == STATUS_DONE || rsp_status == STATUS_DUP
                      || rsp_status == STATUS_FULL)
        else $error("undefined status code");

endmodule

bind masked_subnet_table_top mst_checker u_mst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_hit    (rsp.hit),
    .rsp_status (rsp.status)
);

// File: tb/sv/mst_checker.sv
// result checker for the masked subnet table: watches both channels, keeps its
// own copy of the table, predicts each result and compares it in order
// depends on mst_pkg, mst_req_if and mst_rsp_if
`timescale 1ns / 1ps

module mst_tb_checker #(
    parameter int unsigned ENTRIES = mst_pkg::ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mst_req_if   req,
    mst_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding
);
    import mst_pkg::*;

    typedef struct packed {
        logic                hit;
        logic [STATUS_W-1:0] status;
    } subnet_result_t;

    // shadow table, filled from slot 0 upward
    logic [ADDR_W-1:0] shadow_addr [ENTRIES];
    logic [ADDR_W-1:0] shadow_mask [ENTRIES];
    logic              shadow_live [ENTRIES];
    int unsigned       shadow_fill;

    subnet_result_t    awaited_results [$];

    // applies one request to the shadow table and returns its result
    function automatic subnet_result_t apply_request(
        input logic [KIND_W-1:0] kind,
        input logic [ADDR_W-1:0] address,
        input logic [ADDR_W-1:0] mask
    );
        subnet_result_t res;
        logic           found;
        res   = '0;
        found = 1'b0;
        case (kind)
            KIND_INSERT:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_live[i] && shadow_addr[i] == address && shadow_mask[i] == mask)
                        found = 1'b1;
                end
                if (found)
                begin
                    res.hit    = 1'b1;
                    res.status = STATUS_DUP;
                end
                else if (shadow_fill >= ENTRIES)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    shadow_addr[shadow_fill] = address;
                    shadow_mask[shadow_fill] = mask;
                    shadow_live[shadow_fill] = 1'b1;
                    shadow_fill++;
                    res.status = STATUS_DONE;
                end
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    shadow_live[i] = 1'b0;
                shadow_fill = 0;
            end
            KIND_MATCH:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_live[i] && ((address ^ shadow_addr[i]) & shadow_mask[i]) == '0)
                        res.hit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        subnet_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            for (int i = 0; i < ENTRIES; i++)
                shadow_live[i] = 1'b0;
            shadow_fill = 0;
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got hit %0b status %0d",
                             $time, rsp.hit, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, want.hit, rsp.hit);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                awaited_results.push_back(apply_request(req.kind, req.address, req.prefix_mask));
            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// testbench top for the masked subnet table: clock, reset, request stimulus,
// result back-pressure and the final verdict
// depends on mst_pkg, mst_req_if, mst_rsp_if, mst_tb_checker and the block itself
`timescale 1ns / 1ps

module tb;
    import mst_pkg::*;

    // kind code with no operation behind it
    localparam logic [KIND_W-1:0] KIND_NOOP = 2'd3;

    localparam int unsigned ITEMS_PER_PHASE = 600;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    // drain time before the verdict, sized from the table depth
    localparam int unsigned DRAIN_CYCLES    = 4 * (ENTRIES_DEF + 4);

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } subnet_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;

    // idle percentages of sender and receiver, changed per phase
    int unsigned send_idle_pct = 24;
    int unsigned recv_idle_pct = 82;

    // latest subnets sent since the last clear, reused for duplicates and probes
    subnet_t     known_subnets [$];

    mst_req_if req ();
    mst_rsp_if rsp ();

    masked_subnet_table_top #(
        .ENTRIES (ENTRIES_DEF)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    mst_tb_checker #(
        .ENTRIES (ENTRIES_DEF)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // receiver back-pressure, held low in reset, random per cycle afterwards
    always @(posedge clk)
    begin
        rsp.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: a hung block ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // offers one request after a random gap and returns at the edge that takes it;
    // valid stays high so a following request can go out back to back
    task automatic send_request(
        input logic [KIND_W-1:0] kind,
        input logic [ADDR_W-1:0] address,
        input logic [ADDR_W-1:0] mask
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.kind        <= kind;
        req.address     <= address;
        req.prefix_mask <= mask;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
    endtask

    // sender holds off until every result that is owed has come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // one random request, mostly well-formed subnets and probes related to them
    task automatic random_request();
        int unsigned       pick;
        int unsigned       sel;
        int unsigned       len;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] m;
        subnet_t           s;
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            known_subnets.delete();
            send_request(KIND_CLEAR, $urandom, $urandom);
        end
        else if (pick < 6)
        begin
            send_request(KIND_NOOP, $urandom, $urandom);
        end
        else if (pick < 46)
        begin
            sel = $urandom_range(9);
            if (sel < 3 && known_subnets.size() > 0)
            begin
                // repeat of an earlier pair, duplicate unless it was dropped
                s = known_subnets[$urandom_range(known_subnets.size() - 1)];
                a = s.addr;
                m = s.mask;
            end
            else if (sel < 9)
            begin
                // prefix style mask, base with or without host bits
                len = $urandom_range(ADDR_W);
                m   = {ADDR_W{1'b1}} << (ADDR_W - len);
                a   = $urandom;
                if ($urandom_range(1))
                    a = a & m;
            end
            else
            begin
                // arbitrary, non contiguous mask
                a = $urandom;
                m = $urandom;
            end
            known_subnets.push_back('{a, m});
            if (known_subnets.size() > 24)
                void'(known_subnets.pop_front());
            send_request(KIND_INSERT, a, m);
        end
        else
        begin
            sel = $urandom_range(3);
            if (sel < 3 && known_subnets.size() > 0)
            begin
                s = known_subnets[$urandom_range(known_subnets.size() - 1)];
                // inside the subnet: only bits outside the mask are disturbed
                a = s.addr ^ ($urandom & ~s.mask);
                // near miss: one more flipped bit, a miss when it lands under the mask
                if (sel == 2)
                    a = a ^ (32'h1 << $urandom_range(ADDR_W - 1));
            end
            else
            begin
                a = $urandom;
            end
            send_request(KIND_MATCH, a, $urandom);
        end
    endtask

    initial
    begin
        req.valid       <= 1'b0;
        req.kind        <= KIND_INSERT;
        req.address     <= '0;
        req.prefix_mask <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        // empty table never hits
        send_request(KIND_MATCH, 32'h0000_0000, 32'hFFFF_FFFF);
        // unused kind with every field bit set
        send_request(KIND_NOOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // exact host entry at the top of the address space
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_MATCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_MATCH, 32'hFFFF_FFFE, 32'h0000_0000);
        // host bits outside the mask stay in the stored pair
        send_request(KIND_INSERT, 32'h0A01_0203, 32'hFFFF_FF00);
        send_request(KIND_INSERT, 32'h0A01_0203, 32'hFFFF_FF00);
        send_request(KIND_MATCH, 32'h0A01_02C8, 32'h0000_0000);
        // fill the rest, the first one with a zero mask that matches anything
        send_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        for (int i = 1; i < ENTRIES_DEF - 2; i++)
            send_request(KIND_INSERT, 32'hC0A8_0000 | (i << 8), 32'hFFFF_FF00);
        // full table drops a new pair, but a duplicate still answers as duplicate
        send_request(KIND_INSERT, 32'h1234_5678, 32'hFFFF_0000);
        send_request(KIND_INSERT, 32'h0A01_0203, 32'hFFFF_FF00);
        send_request(KIND_MATCH, 32'h5555_AAAA, 32'h0000_0000);
        send_request(KIND_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_MATCH, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_drained();

        // random part: slow sender / slow receiver, then swapped, then flat out
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_request();
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mst_pkg.sv
hw/rtl/mst_req_if.sv
hw/rtl/mst_rsp_if.sv
hw/rtl/mst_ram.sv
hw/rtl/masked_subnet_table_top.sv
hw/rtl/mst_checker.sv
tb/sv/mst_checker.sv
tb/sv/tb.sv
